// ----- rtl/lpc_pkg.sv -----
// Package for the frame payload counter-mode cipher: widths, register
// indexes, controller states and AES helper functions. No dependencies.
`default_nettype none
package lpc_pkg;
    localparam int AES_ROUNDS_DEF = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FCNT     = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_XOR   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;   // load counter block and first key add
        logic round;  // run one AES round
        logic emit;   // produce output word from held byte
        logic take;   // capture input word
    } t_cmd;

    typedef struct packed {
        logic need_ks;  // current byte opens a block
        logic last_rnd; // round counter at final round
    } t_stat;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] gf2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/lpc_if.sv -----
// Valid/ready channel carrying one word of byte payload and an end flag.
// Depends on nothing.
`default_nettype none
interface lpc_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       last;
    modport source (output valid, output data, output last, input ready);
    modport sink (input valid, input data, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/lpc_ctrl.sv -----
// Controller: sequences word capture, AES rounds and output handoff.
// Depends on lpc_pkg.
`default_nettype none
module lpc_ctrl import lpc_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.need_ks) begin
                        o_cmd.load = 1'b1;
                        n_state = ST_ROUND;
                    end else begin
                        n_state = ST_XOR;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.last_rnd) n_state = ST_XOR;
            end
            ST_XOR: begin
                o_cmd.emit = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/lpc_dp.sv -----
// Datapath: config registers, block/byte counters, round-iterative AES-128
// and keystream XOR. Depends on lpc_pkg.
`default_nettype none
module lpc_dp import lpc_pkg::*; #(
    parameter int AES_ROUNDS = AES_ROUNDS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire [7:0]            i_byte,
    input  wire                  i_last,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [7:0]           o_byte,
    output logic                 o_last
);
    localparam int RW = $clog2(AES_ROUNDS + 1);

    logic [63:0]  r_key_hi, r_key_lo;
    logic [31:0]  r_dev, r_fcnt;
    logic         r_dir;
    logic [7:0]   r_blk;
    logic [3:0]   r_pos;
    logic [RW-1:0] r_rnd;
    logic [7:0]   r_rc;
    logic [127:0] r_st, r_rk, n_st, n_rk, r_ks;
    logic [7:0]   r_pb, r_ob;
    logic         r_pl, r_ol;
    logic [127:0] blk;

    // byte i of the model sits at bits [127-8i -: 8]
    function automatic logic [7:0] gb(input logic [127:0] v, input int i);
        return v[127-8*i -: 8];
    endfunction

    always_comb begin
        blk = '0;
        blk[127 -: 8]   = 8'h01;
        blk[127-40 -: 8] = {7'd0, r_dir};
        for (int i = 0; i < 4; i++) begin
            blk[127-8*(6+i) -: 8]  = r_dev[8*i +: 8];
            blk[127-8*(10+i) -: 8] = r_fcnt[8*i +: 8];
        end
        blk[7:0] = r_blk;
    end

    logic [7:0] ss [16];
    logic [7:0] mc [16];
    logic [7:0] t [4];
    logic [7:0] k [16];
    always_comb begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                ss[r+4*c] = sbox(gb(r_st, r + 4*((c + r) & 3)));
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = ss[4*c]; a1 = ss[4*c+1]; a2 = ss[4*c+2]; a3 = ss[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (r_rnd == RW'(AES_ROUNDS)) begin
                mc[4*c] = a0; mc[4*c+1] = a1; mc[4*c+2] = a2; mc[4*c+3] = a3;
            end else begin
                mc[4*c]   = a0 ^ al ^ gf2(a0 ^ a1);
                mc[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
                mc[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
                mc[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
            end
        end
        t[0] = sbox(gb(r_rk, 13)) ^ r_rc;
        t[1] = sbox(gb(r_rk, 14));
        t[2] = sbox(gb(r_rk, 15));
        t[3] = sbox(gb(r_rk, 12));
        for (int i = 0; i < 4; i++) k[i] = gb(r_rk, i) ^ t[i];
        for (int i = 4; i < 16; i++) k[i] = gb(r_rk, i) ^ k[i-4];
        for (int i = 0; i < 16; i++) begin
            n_rk[127-8*i -: 8] = k[i];
            n_st[127-8*i -: 8] = mc[i] ^ k[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0; r_key_lo <= '0; r_dev <= '0; r_dir <= 1'b0;
            r_fcnt <= '0; r_blk <= 8'h01; r_pos <= '0; r_rnd <= '0;
            r_rc <= 8'h01; r_st <= '0; r_rk <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_HIGH: r_key_hi <= i_cfg_data;
                    REG_KEY_LOW:  r_key_lo <= i_cfg_data;
                    REG_DEV_ADDR: r_dev <= i_cfg_data[31:0];
                    REG_DIR:      r_dir <= i_cfg_data[0];
                    REG_FCNT:     r_fcnt <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_st  <= blk ^ {r_key_hi, r_key_lo};
                r_rk  <= {r_key_hi, r_key_lo};
                r_rc  <= 8'h01;
                r_rnd <= RW'(1);
            end else if (i_cmd.round) begin
                r_st  <= n_st;
                r_rk  <= n_rk;
                r_rc  <= gf2(r_rc);
                r_rnd <= r_rnd + RW'(1);
            end
            if (i_cmd.emit) begin
                if (r_pl) begin
                    r_blk <= 8'h01; r_pos <= '0;
                end else if (r_pos == 4'd15) begin
                    r_pos <= '0; r_blk <= r_blk + 8'd1;
                end else begin
                    r_pos <= r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pb <= i_byte;
            r_pl <= i_last;
        end
        if (i_cmd.round && o_stat.last_rnd) r_ks <= n_st;
        if (i_cmd.emit) begin
            r_ob <= r_pb ^ ((r_pos == 4'd0) ? r_st[127 -: 8] : gb(r_ks, 32'(r_pos)));
            r_ol <= r_pl;
        end
    end

    // on a block's first byte the emit cycle follows the last round,
    // so the keystream byte is still in r_st
    assign o_stat.need_ks  = (r_pos == 4'd0);
    assign o_stat.last_rnd = (r_rnd == RW'(AES_ROUNDS));
    assign o_byte = r_ob;
    assign o_last = r_ol;
endmodule
`default_nettype wire

// ----- rtl/aes128_counter_payload_cipher.sv -----
// Top level of the frame payload counter-mode cipher.
// Depends on lpc_pkg, lpc_if, lpc_ctrl and lpc_dp.
// Each byte word passes through the idle, XOR and output states and waits in
// the output state through any output stall; the first byte of every 16-byte
// block also runs the round state for each AES round of the shared AES round
// unit, to produce that block's keystream.
`default_nettype none
module aes128_counter_payload_cipher import lpc_pkg::*; #(
    parameter int AES_ROUNDS = AES_ROUNDS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    lpc_if.sink                  in_ch,
    lpc_if.source                out_ch
);
    t_cmd  cmd;
    t_stat stat;

    lpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    lpc_dp #(.AES_ROUNDS(AES_ROUNDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_byte(in_ch.data), .i_last(in_ch.last),
        .i_cmd(cmd), .o_stat(stat),
        .o_byte(out_ch.data), .o_last(out_ch.last)
    );
endmodule
`default_nettype wire

// ----- rtl/lpc_chk.sv -----
// Port-level checker for the cipher top level, with its bind.
// Depends on aes128_counter_payload_cipher, whose lpc_if ports the bind reads.
`default_nettype none
module lpc_chk (
    input wire i_clk,
    input wire i_rst_n,
    input wire in_valid,
    input wire in_ready,
    input wire out_valid,
    input wire out_ready,
    input wire out_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("output dropped");
    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_last)) else $error("last moved");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("input taken with output pending");
    a_take_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind aes128_counter_payload_cipher lpc_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last)
);
`default_nettype wire
